FILE: rtl/core/ordered_key_value_table_unit_assert.svh
// Assertion macros used by the ordered key/value table RTL.
`ifndef ORDERED_KEY_VALUE_TABLE_UNIT_ASSERT_SVH
`define ORDERED_KEY_VALUE_TABLE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define OKV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("okv assertion failed");
// Condition must never be true at a clock edge outside reset.
`define OKV_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("okv forbidden condition seen");
`else
`define OKV_ASSERT(lbl, prop)
`define OKV_ASSERT_NEVER(lbl, cond)
`endif

`endif

FILE: rtl/core/okv_pkg.sv
// Shared constants, codes and types of the ordered key/value table.
`default_nettype none

package okv_pkg;

  // Table geometry.
  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths.
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned ST_W    = 2;
  localparam int unsigned KEY_W   = 31;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned ENTRY_W = KEY_W + VAL_W;
  localparam int unsigned TDATA_W = ((ENTRY_W + 7) / 8) * 8;

  // Command codes carried in the input tuser.
  typedef enum logic [ACT_W-1:0] {
    ACT_PUT    = 3'd0,
    ACT_GET    = 3'd1,
    ACT_LIST   = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_DELETE = 3'd4
  } action_e;

  // Result status codes carried in the output tuser.
  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // Memory access request from the controller to the table RAM.
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [IDX_W-1:0]   raddr;
  } mem_req_t;

  // One result transaction.
  typedef struct packed {
    status_e            status;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
    logic               last;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/okv_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module okv_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 16,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write port and registered read port; read data holds when no read is issued.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/okv_ctrl.sv
// Command sequencer: searches, updates, shifts and lists the table held in RAM.
`default_nettype none
`include "ordered_key_value_table_unit_assert.svh"

module okv_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [okv_pkg::ACT_W-1:0]   in_action_i,
  input  wire logic [okv_pkg::KEY_W-1:0]   in_key_i,
  input  wire logic [okv_pkg::VAL_W-1:0]   in_value_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output okv_pkg::result_t                 out_res_o,
  output okv_pkg::mem_req_t                mem_req_o,
  input  wire logic [okv_pkg::ENTRY_W-1:0] mem_rdata_i
);
  import okv_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_RESP,
    S_SHIFT,
    S_LIST_RD,
    S_LIST_OUT
  } state_e;

  state_e             state_q, state_d;
  action_e            action_q, action_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [VAL_W-1:0]   value_q, value_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic               cmp_valid_q, cmp_valid_d;
  logic [IDX_W-1:0]   cmp_idx_q, cmp_idx_d;
  result_t            res_q, res_d;
  logic               out_valid_q, out_valid_d;
  result_t            out_q, out_d;

  logic               accept;
  logic               out_free;
  logic               emit;
  logic [KEY_W-1:0]   rd_key;
  logic [VAL_W-1:0]   rd_val;
  logic               match;
  logic               list_last;
  mem_req_t           mem_req;

  assign rd_key    = mem_rdata_i[KEY_W-1:0];
  assign rd_val    = mem_rdata_i[ENTRY_W-1:KEY_W];
  assign match     = cmp_valid_q && (rd_key == key_q);
  assign out_free  = !out_valid_q || out_ready_i;
  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign list_last = ((idx_q + CNT_W'(1)) == count_q);

  // Next-state logic for the sequencer, the memory port and the output register.
  always_comb begin
    state_d     = state_q;
    action_d    = action_q;
    key_d       = key_q;
    value_d     = value_q;
    count_d     = count_q;
    idx_d       = idx_q;
    cmp_valid_d = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    res_d       = res_q;
    out_d       = out_q;
    emit        = 1'b0;
    mem_req     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          action_d = action_e'(in_action_i);
          key_d    = in_key_i;
          value_d  = in_value_i;
          idx_d    = '0;
          unique case (in_action_i)
            ACT_PUT, ACT_GET, ACT_DELETE: begin
              state_d = S_SEARCH;
            end
            ACT_LIST: begin
              if (count_q == '0) begin
                res_d   = '{status: ST_EMPTY, key: '0, value: '0, last: 1'b1};
                state_d = S_RESP;
              end else begin
                state_d = S_LIST_RD;
              end
            end
            ACT_CLEAR: begin
              count_d = '0;
              res_d   = '{status: ST_OK, key: '0, value: '0, last: 1'b1};
              state_d = S_RESP;
            end
            default: begin
              // Unknown commands are dropped without a result.
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // One read issued and one key compared per cycle, oldest entry first.
      S_SEARCH: begin
        if (match) begin
          res_d.last = 1'b1;
          if (action_q == ACT_PUT) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = cmp_idx_q;
            mem_req.wdata = {value_q, key_q};
            res_d.status  = ST_OK;
            res_d.key     = key_q;
            res_d.value   = value_q;
          end else begin
            res_d.status  = ST_OK;
            res_d.key     = rd_key;
            res_d.value   = rd_val;
          end
          state_d = S_RESP;
        end else if (idx_q < count_q) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_q[IDX_W-1:0];
          cmp_valid_d   = 1'b1;
          cmp_idx_d     = idx_q[IDX_W-1:0];
          idx_d         = idx_q + CNT_W'(1);
        end else if (!cmp_valid_q) begin
          res_d.last = 1'b1;
          res_d.key  = key_q;
          if (action_q == ACT_PUT) begin
            if (count_q < CNT_W'(TABLE_DEPTH)) begin
              mem_req.we    = 1'b1;
              mem_req.waddr = count_q[IDX_W-1:0];
              mem_req.wdata = {value_q, key_q};
              count_d       = count_q + CNT_W'(1);
              res_d.status  = ST_OK;
              res_d.value   = value_q;
            end else begin
              res_d.status  = ST_FULL;
              res_d.value   = '0;
            end
          end else begin
            res_d.status = ST_NOT_FOUND;
            res_d.value  = '0;
          end
          state_d = S_RESP;
        end
      end

      // Single result; a successful delete then closes the gap.
      S_RESP: begin
        if (out_free) begin
          emit  = 1'b1;
          out_d = res_q;
          if (action_q == ACT_DELETE && res_q.status == ST_OK) begin
            idx_d   = CNT_W'(cmp_idx_q) + CNT_W'(1);
            state_d = S_SHIFT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      // Read entry j and write it to j-1 in the next cycle.
      S_SHIFT: begin
        if (cmp_valid_q) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = cmp_idx_q;
          mem_req.wdata = mem_rdata_i;
        end
        if (idx_q < count_q) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_q[IDX_W-1:0];
          cmp_valid_d   = 1'b1;
          cmp_idx_d     = IDX_W'(idx_q - CNT_W'(1));
          idx_d         = idx_q + CNT_W'(1);
        end else if (!cmp_valid_q) begin
          count_d = count_q - CNT_W'(1);
          state_d = S_IDLE;
        end
      end

      S_LIST_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = idx_q[IDX_W-1:0];
        state_d       = S_LIST_OUT;
      end

      S_LIST_OUT: begin
        if (out_free) begin
          emit  = 1'b1;
          out_d = '{status: ST_OK, key: rd_key, value: rd_val, last: list_last};
          if (list_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + CNT_W'(1);
            state_d = S_LIST_RD;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Output register: loaded on emit, emptied when the transaction is taken.
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Sequencer state and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      action_q    <= ACT_PUT;
      key_q       <= '0;
      value_q     <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      cmp_valid_q <= 1'b0;
      cmp_idx_q   <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      action_q    <= action_d;
      key_q       <= key_d;
      value_q     <= value_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      cmp_valid_q <= cmp_valid_d;
      cmp_idx_q   <= cmp_idx_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign mem_req_o   = mem_req;

  // The same entry is never read and written in one cycle.
  `OKV_ASSERT_NEVER(a_no_rw_same_entry,
    mem_req.we && mem_req.re && (mem_req.waddr == mem_req.raddr))
  // The entry count stays within the table.
  `OKV_ASSERT_NEVER(a_count_in_range, count_q > CNT_W'(TABLE_DEPTH))
  // Writes land on a valid entry or on the next free slot.
  `OKV_ASSERT_NEVER(a_write_in_range, mem_req.we && (CNT_W'(mem_req.waddr) > count_q))
  // A waiting result is never overwritten.
  `OKV_ASSERT_NEVER(a_no_out_overwrite, emit && out_valid_q && !out_ready_i)
  // Finishing a delete shift removes exactly one entry.
  `OKV_ASSERT(a_shift_drops_one,
    (state_q == S_SHIFT && state_d == S_IDLE) |=> (count_q == $past(count_q) - CNT_W'(1)))

endmodule

`default_nettype wire

FILE: rtl/core/ordered_key_value_table_unit.sv
// Put, get and delete scan one entry per cycle, oldest first, and answer once the
// key is found or every entry has been read. A delete then shifts the later
// entries down, one per cycle, before the next command is taken. List all reads
// each entry and waits until it is sent before reading the next; clear only resets
// the entry count. The RAM's single read port sets the scan rate. Reset empties
// the table (count to zero) at once; the RAM contents need no clearing pass.
`default_nettype none

module ordered_key_value_table_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // Fields from bit 0: key (31), value (32), zero pad.
  input  wire logic [okv_pkg::TDATA_W-1:0] s_axis_tdata,
  // Fields from bit 0: action (3).
  input  wire logic [okv_pkg::ACT_W-1:0]   s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // Fields from bit 0: key_out (31), value_out (32), zero pad.
  output logic      [okv_pkg::TDATA_W-1:0] m_axis_tdata,
  // Fields from bit 0: status (2).
  output logic      [okv_pkg::ST_W-1:0]    m_axis_tuser,
  output logic                             m_axis_tlast
);
  import okv_pkg::*;

  mem_req_t             mem_req;
  logic [ENTRY_W-1:0]   mem_rdata;
  result_t              res;

  // Command sequencer.
  okv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_action_i (s_axis_tuser),
    .in_key_i    (s_axis_tdata[KEY_W-1:0]),
    .in_value_i  (s_axis_tdata[ENTRY_W-1:KEY_W]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // Key/value storage, one entry per word.
  okv_ram #(
    .DATA_W (ENTRY_W),
    .DEPTH  (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  // Result packing onto the master stream.
  assign m_axis_tdata = TDATA_W'({res.value, res.key});
  assign m_axis_tuser = res.status;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the ordered key/value table unit.
`timescale 1ns / 1ps

module testbench;
  import okv_pkg::*;

  // Action codes outside the defined set; the block must ignore them.
  localparam logic [ACT_W-1:0] ACT_SPARE_A = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_B = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_C = 3'd7;

  localparam logic [KEY_W-1:0] KEY_MAX = '1;
  localparam logic [VAL_W-1:0] VAL_MAX = '1;
  localparam int IDLE_PCT       = 38;
  localparam int SINK_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 300;
  localparam int RANDOM_ITEMS   = 80;
  localparam int KEY_POOL_SIZE  = 10;

  // One command, with an optional hand-written reply.
  typedef struct {
    logic [ACT_W-1:0] act;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    bit               typed;
    result_t          reply;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [TDATA_W-1:0]  s_axis_tdata;
  logic [ACT_W-1:0]    s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [TDATA_W-1:0]  m_axis_tdata;
  logic [ST_W-1:0]     m_axis_tuser;
  logic                m_axis_tlast;

  // Shadow copy of the table, kept in insertion order.
  logic [KEY_W-1:0] table_keys [TABLE_DEPTH];
  logic [VAL_W-1:0] table_vals [TABLE_DEPTH];
  int               table_count = 0;

  result_t   pending_replies[$];
  stim_row_t directed_rows[$];
  int        fail_count    = 0;
  int        commands_sent = 0;
  int        hold_start    = 32'h7FFF_FFFF;
  int        src_idle_pct  = IDLE_PCT;
  int        sink_idle_pct = IDLE_PCT;

  ordered_key_value_table_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Upper bound on the whole run.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic result_t make_reply(status_e st, logic [KEY_W-1:0] k,
                                         logic [VAL_W-1:0] v, logic lst);
    result_t r;
    r.status = st;
    r.key    = k;
    r.value  = v;
    r.last   = lst;
    return r;
  endfunction

  function automatic stim_row_t plain_row(logic [ACT_W-1:0] act, logic [KEY_W-1:0] key,
                                          logic [VAL_W-1:0] value);
    stim_row_t row;
    row.act   = act;
    row.key   = key;
    row.value = value;
    row.typed = 1'b0;
    row.reply = '0;
    return row;
  endfunction

  function automatic stim_row_t typed_row(logic [ACT_W-1:0] act, logic [KEY_W-1:0] key,
                                          logic [VAL_W-1:0] value, status_e st,
                                          logic [KEY_W-1:0] k_out, logic [VAL_W-1:0] v_out);
    stim_row_t row;
    row       = plain_row(act, key, value);
    row.typed = 1'b1;
    row.reply = make_reply(st, k_out, v_out, 1'b1);
    return row;
  endfunction

  // Applies one command to the shadow table and returns the replies it owes.
  task automatic table_replies(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                               input logic [VAL_W-1:0] value, output result_t replies[$]);
    int hit;
    replies = {};
    // The first matching entry, oldest first; table_count means no match.
    hit = table_count;
    for (int i = table_count - 1; i >= 0; i--) begin
      if (table_keys[i] == key) hit = i;
    end
    case (act)
      ACT_PUT: begin
        if (hit < table_count) begin
          table_vals[hit] = value;
          replies.push_back(make_reply(ST_OK, key, value, 1'b1));
        end else if (table_count < TABLE_DEPTH) begin
          table_keys[table_count] = key;
          table_vals[table_count] = value;
          table_count++;
          replies.push_back(make_reply(ST_OK, key, value, 1'b1));
        end else begin
          replies.push_back(make_reply(ST_FULL, key, '0, 1'b1));
        end
      end
      ACT_GET: begin
        if (hit < table_count)
          replies.push_back(make_reply(ST_OK, table_keys[hit], table_vals[hit], 1'b1));
        else
          replies.push_back(make_reply(ST_NOT_FOUND, key, '0, 1'b1));
      end
      ACT_LIST: begin
        if (table_count == 0)
          replies.push_back(make_reply(ST_EMPTY, '0, '0, 1'b1));
        for (int i = 0; i < table_count; i++)
          replies.push_back(make_reply(ST_OK, table_keys[i], table_vals[i],
                                       i == table_count - 1));
      end
      ACT_CLEAR: begin
        table_count = 0;
        replies.push_back(make_reply(ST_OK, '0, '0, 1'b1));
      end
      ACT_DELETE: begin
        if (hit >= table_count) begin
          replies.push_back(make_reply(ST_NOT_FOUND, key, '0, 1'b1));
        end else begin
          replies.push_back(make_reply(ST_OK, table_keys[hit], table_vals[hit], 1'b1));
          for (int i = hit; i + 1 < table_count; i++) begin
            table_keys[i] = table_keys[i + 1];
            table_vals[i] = table_vals[i + 1];
          end
          table_count--;
        end
      end
      default: ;
    endcase
  endtask

  // Offers one command after a random gap and records its replies once taken.
  // Returns at the rising edge where the transaction happened.
  task automatic send_command(input stim_row_t row);
    result_t replies[$];
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= row.act;
    s_axis_tdata  <= {{(TDATA_W - ENTRY_W){1'b0}}, row.value, row.key};
    do @(posedge clk_i); while (!s_axis_tready);
    table_replies(row.act, row.key, row.value, replies);
    if (row.typed)
      pending_replies.push_back(row.reply);
    else
      foreach (replies[i]) pending_replies.push_back(replies[i]);
    commands_sent++;
  endtask

  // Withdraws the offer and waits until every owed reply has arrived.
  task automatic drain_replies();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  // Receiver side: random back-pressure plus one long hold-off.
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && commands_sent >= hold_start) begin
        hold_left = SINK_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Compare every reply transaction with the oldest owed reply.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected reply: status %0d key %0h value %0h last %0b",
               m_axis_tuser, m_axis_tdata[KEY_W-1:0],
               m_axis_tdata[ENTRY_W-1:KEY_W], m_axis_tlast);
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tdata[KEY_W-1:0] !== want.key) begin
          $error("key_out: expected %0h, got %0h", want.key, m_axis_tdata[KEY_W-1:0]);
          fail_count++;
        end
        if (m_axis_tdata[ENTRY_W-1:KEY_W] !== want.value) begin
          $error("value_out: expected %0h, got %0h", want.value,
                 m_axis_tdata[ENTRY_W-1:KEY_W]);
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  // Main stimulus sequence.
  initial begin
    logic [KEY_W-1:0] fill_keys [TABLE_DEPTH];
    logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];
    logic [KEY_W-1:0] k;
    logic [ACT_W-1:0] act;
    int               roll;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ACT_PUT;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed commands: extremes, every action and the corner cases.
    directed_rows.push_back(typed_row(ACT_LIST, '0, '0, ST_EMPTY, '0, '0));
    directed_rows.push_back(typed_row(ACT_GET, '0, '0, ST_NOT_FOUND, '0, '0));
    directed_rows.push_back(typed_row(ACT_DELETE, KEY_MAX, VAL_MAX, ST_NOT_FOUND,
                                      KEY_MAX, '0));
    directed_rows.push_back(typed_row(ACT_PUT, '0, '0, ST_OK, '0, '0));
    directed_rows.push_back(typed_row(ACT_PUT, KEY_MAX, VAL_MAX, ST_OK, KEY_MAX, VAL_MAX));
    directed_rows.push_back(typed_row(ACT_PUT, 31'h2AAA_AAAA, 32'h5555_5555, ST_OK,
                                      31'h2AAA_AAAA, 32'h5555_5555));
    directed_rows.push_back(typed_row(ACT_PUT, 31'h5555_5555, 32'hAAAA_AAAA, ST_OK,
                                      31'h5555_5555, 32'hAAAA_AAAA));
    directed_rows.push_back(plain_row(ACT_GET, KEY_MAX, '0));
    directed_rows.push_back(plain_row(ACT_PUT, '0, 32'h1234_5678));
    directed_rows.push_back(plain_row(ACT_LIST, '0, '0));
    directed_rows.push_back(plain_row(ACT_SPARE_A, 31'd1, 32'd1));
    directed_rows.push_back(plain_row(ACT_SPARE_B, KEY_MAX, VAL_MAX));
    directed_rows.push_back(plain_row(ACT_SPARE_C, '0, '0));
    directed_rows.push_back(plain_row(ACT_GET, '0, VAL_MAX));
    directed_rows.push_back(plain_row(ACT_DELETE, 31'h2AAA_AAAA, '0));
    directed_rows.push_back(plain_row(ACT_DELETE, '0, '0));
    directed_rows.push_back(plain_row(ACT_LIST, '0, '0));
    directed_rows.push_back(typed_row(ACT_DELETE, 31'd99, '0, ST_NOT_FOUND, 31'd99, '0));
    directed_rows.push_back(typed_row(ACT_CLEAR, KEY_MAX, VAL_MAX, ST_OK, '0, '0));
    directed_rows.push_back(typed_row(ACT_LIST, '0, '0, ST_EMPTY, '0, '0));
    directed_rows.push_back(typed_row(ACT_GET, KEY_MAX, '0, ST_NOT_FOUND, KEY_MAX, '0));
    directed_rows.push_back(plain_row(ACT_PUT, KEY_MAX, 32'h8000_0001));
    directed_rows.push_back(plain_row(ACT_DELETE, KEY_MAX, '0));
    directed_rows.push_back(typed_row(ACT_LIST, '0, '0, ST_EMPTY, '0, '0));
    foreach (directed_rows[i]) send_command(directed_rows[i]);

    // Fill the table to the brim with no idling on either side.
    drain_replies();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    send_command(plain_row(ACT_CLEAR, '0, '0));
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      k                  = KEY_W'($urandom());
      k[IDX_W-1:0]       = i[IDX_W-1:0];
      fill_keys[i]       = k;
      send_command(plain_row(ACT_PUT, k, $urandom()));
    end
    // Its low index bits set this key apart from every stored one but the first, and the flipped bit from that one.
    k = fill_keys[0] ^ (KEY_W'(1) << IDX_W);
    send_command(plain_row(ACT_PUT, k, $urandom()));
    send_command(plain_row(ACT_PUT, fill_keys[TABLE_DEPTH-1], $urandom()));
    send_command(plain_row(ACT_GET, fill_keys[TABLE_DEPTH-1], '0));
    send_command(plain_row(ACT_LIST, '0, '0));
    send_command(plain_row(ACT_DELETE, fill_keys[0], '0));
    send_command(plain_row(ACT_PUT, k, $urandom()));
    send_command(plain_row(ACT_PUT, fill_keys[0], $urandom()));
    send_command(plain_row(ACT_CLEAR, '0, '0));
    src_idle_pct  = IDLE_PCT;
    sink_idle_pct = IDLE_PCT;

    // Random traffic over a small key set so that most lookups hit.
    foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom());
    key_pool[0] = '0;
    key_pool[1] = KEY_MAX;
    hold_start  = commands_sent + 30;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Let the replies catch up once while the sender stands still.
      if (n == 60) drain_replies();
      k    = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
      roll = $urandom_range(99);
      if (roll < 35)      act = ACT_PUT;
      else if (roll < 58) act = ACT_GET;
      else if (roll < 78) act = ACT_DELETE;
      else if (roll < 87) act = ACT_LIST;
      else if (roll < 90) act = ACT_CLEAR;
      else if (roll < 94) begin
        act = ACT_W'(ACT_SPARE_A + $urandom_range(ACT_SPARE_C - ACT_SPARE_A));
      end
      else begin
        act = ACT_GET;
        k   = KEY_W'($urandom());
      end
      send_command(plain_row(act, k, $urandom()));
    end

    // Wait out the last replies and any trailing shift work.
    drain_replies();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
